// File: src/hre_pkg.sv
// ----------------------------------------------------------------------------
// hre_pkg
// shared types, constants and the sequencer microcode for the hex record
// encoder
// ----------------------------------------------------------------------------
package hre_pkg;

   // record geometry
   localparam int REC_BYTES = 16;
   localparam int FILL_W    = $clog2(REC_BYTES + 1);
   localparam int IDX_W     = (REC_BYTES > 1) ? $clog2(REC_BYTES) : 1;
   localparam int PC_W      = 6;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_ADDRESS  = 2'd1;

   // record formats
   localparam logic FMT_INTEL  = 1'b0;
   localparam logic FMT_MOSTEK = 1'b1;

   // ascii characters
   localparam logic [6:0] CHR_0     = 7'h30;
   localparam logic [6:0] CHR_1     = 7'h31;
   localparam logic [6:0] CHR_F     = 7'h46;
   localparam logic [6:0] CHR_A     = 7'h41;
   localparam logic [6:0] CHR_LF    = 7'h0A;
   localparam logic [6:0] CHR_COLON = 7'h3A;
   localparam logic [6:0] CHR_SEMI  = 7'h3B;

   // character source
   localparam logic [1:0] CK_START = 2'd0;
   localparam logic [1:0] CK_HEX   = 2'd1;
   localparam logic [1:0] CK_LIT   = 2'd2;

   // nibble source for hex digits
   localparam logic [3:0] NS_CNT_HI = 4'd0;
   localparam logic [3:0] NS_CNT_LO = 4'd1;
   localparam logic [3:0] NS_A3     = 4'd2;
   localparam logic [3:0] NS_A2     = 4'd3;
   localparam logic [3:0] NS_A1     = 4'd4;
   localparam logic [3:0] NS_A0     = 4'd5;
   localparam logic [3:0] NS_D_HI   = 4'd6;
   localparam logic [3:0] NS_D_LO   = 4'd7;
   localparam logic [3:0] NS_K3     = 4'd8;
   localparam logic [3:0] NS_K2     = 4'd9;
   localparam logic [3:0] NS_K1     = 4'd10;
   localparam logic [3:0] NS_K0     = 4'd11;

   // jump conditions
   localparam logic [2:0] JC_NONE     = 3'd0;
   localparam logic [2:0] JC_ALWAYS   = 3'd1;
   localparam logic [2:0] JC_MOSTEK   = 3'd2;
   localparam logic [2:0] JC_INTEL    = 3'd3;
   localparam logic [2:0] JC_MORE     = 3'd4;
   localparam logic [2:0] JC_NOT_LAST = 3'd5;

   // datapath actions
   localparam logic [1:0] ACT_NONE      = 2'd0;
   localparam logic [1:0] ACT_NEXT_BYTE = 2'd1;
   localparam logic [1:0] ACT_FINISH    = 2'd2;
   localparam logic [1:0] ACT_RELOAD    = 2'd3;

   // end-of-run marking
   localparam logic [1:0] LK_NONE = 2'd0;
   localparam logic [1:0] LK_REC  = 2'd1;
   localparam logic [1:0] LK_EOF  = 2'd2;

   // program addresses
   localparam logic [PC_W-1:0] PC_IDLE    = 6'd0;
   localparam logic [PC_W-1:0] PC_START   = 6'd1;
   localparam logic [PC_W-1:0] PC_DATA_HI = 6'd10;
   localparam logic [PC_W-1:0] PC_K1      = 6'd15;
   localparam logic [PC_W-1:0] PC_EOF_M   = 6'd31;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_word_type;

   typedef struct packed {
      logic [6:0] text_char;
      logic       run_last;
   } rsp_word_type;

   typedef struct packed {
      logic            emit;
      logic [1:0]      ck;
      logic [3:0]      nib;
      logic [6:0]      lit;
      logic [2:0]      jc;
      logic [PC_W-1:0] target;
      logic [1:0]      act;
      logic [1:0]      lk;
   } ctrl_word_type;

   function automatic ctrl_word_type cw(input logic emit, input logic [1:0] ck,
                                        input logic [3:0] nib, input logic [6:0] lit,
                                        input logic [2:0] jc, input logic [PC_W-1:0] target,
                                        input logic [1:0] act, input logic [1:0] lk);
      ctrl_word_type w;
      w.emit   = emit;
      w.ck     = ck;
      w.nib    = nib;
      w.lit    = lit;
      w.jc     = jc;
      w.target = target;
      w.act    = act;
      w.lk     = lk;
      return w;
   endfunction

   // one control word per program step
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      case (pc)
         // record header
         6'd1:  w = cw(1'b1, CK_START, NS_CNT_HI, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd2:  w = cw(1'b1, CK_HEX, NS_CNT_HI, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd3:  w = cw(1'b1, CK_HEX, NS_CNT_LO, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd4:  w = cw(1'b1, CK_HEX, NS_A3, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd5:  w = cw(1'b1, CK_HEX, NS_A2, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd6:  w = cw(1'b1, CK_HEX, NS_A1, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd7:  w = cw(1'b1, CK_HEX, NS_A0, CHR_0, JC_MOSTEK, PC_DATA_HI, ACT_NONE, LK_NONE);
         // intel record type
         6'd8:  w = cw(1'b1, CK_LIT, NS_A0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd9:  w = cw(1'b1, CK_LIT, NS_A0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         // data loop
         6'd10: w = cw(1'b1, CK_HEX, NS_D_HI, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd11: w = cw(1'b1, CK_HEX, NS_D_LO, CHR_0, JC_MORE, PC_DATA_HI,
                       ACT_NEXT_BYTE, LK_NONE);
         // checksum
         6'd12: w = cw(1'b0, CK_LIT, NS_K3, CHR_0, JC_INTEL, PC_K1, ACT_NONE, LK_NONE);
         6'd13: w = cw(1'b1, CK_HEX, NS_K3, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd14: w = cw(1'b1, CK_HEX, NS_K2, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd15: w = cw(1'b1, CK_HEX, NS_K1, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd16: w = cw(1'b1, CK_HEX, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd17: w = cw(1'b1, CK_LIT, NS_K0, CHR_LF, JC_NOT_LAST, PC_IDLE, ACT_FINISH, LK_REC);
         // end-of-file record
         6'd18: w = cw(1'b0, CK_LIT, NS_K0, CHR_0, JC_MOSTEK, PC_EOF_M, ACT_NONE, LK_NONE);
         6'd19: w = cw(1'b1, CK_LIT, NS_K0, CHR_COLON, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd20: w = cw(1'b1, CK_LIT, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd21: w = cw(1'b1, CK_LIT, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd22: w = cw(1'b1, CK_LIT, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd23: w = cw(1'b1, CK_LIT, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd24: w = cw(1'b1, CK_LIT, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd25: w = cw(1'b1, CK_LIT, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd26: w = cw(1'b1, CK_LIT, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd27: w = cw(1'b1, CK_LIT, NS_K0, CHR_1, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd28: w = cw(1'b1, CK_LIT, NS_K0, CHR_F, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd29: w = cw(1'b1, CK_LIT, NS_K0, CHR_F, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd30: w = cw(1'b1, CK_LIT, NS_K0, CHR_LF, JC_ALWAYS, PC_IDLE, ACT_RELOAD, LK_EOF);
         6'd31: w = cw(1'b1, CK_LIT, NS_K0, CHR_SEMI, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd32: w = cw(1'b1, CK_LIT, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd33: w = cw(1'b1, CK_LIT, NS_K0, CHR_0, JC_NONE, PC_IDLE, ACT_NONE, LK_NONE);
         6'd34: w = cw(1'b1, CK_LIT, NS_K0, CHR_LF, JC_ALWAYS, PC_IDLE, ACT_RELOAD, LK_EOF);
         // idle and unused steps
         default: w = cw(1'b0, CK_LIT, NS_K0, CHR_0, JC_ALWAYS, PC_IDLE, ACT_NONE, LK_NONE);
      endcase
      return w;
   endfunction

   // uppercase hex digit
   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] c;
      if (nib < 4'd10) begin
         c = CHR_0 + {3'd0, nib};
      end else begin
         c = CHR_A + {3'd0, nib} - 7'd10;
      end
      return c;
   endfunction

endpackage

// File: src/hex_record_encoder.sv
// ----------------------------------------------------------------------------
// hex_record_encoder
// packs a byte stream into intel hex or mostek text records
// ----------------------------------------------------------------------------
// usage: bytes come in on the req_ channel, one word per byte with an end
// flag. bytes are held until a record of REC_BYTES bytes is full or the end
// flag arrives; the record then goes out on the rsp_ channel as ascii text,
// one character per word, with run_last set on the final character caused
// by that byte. the end-of-file record follows the last data record.
// the csr_ channel writes the format (index 0) and the load address
// (index 1); it is ready while the sequencer idles.
// timing: a byte that completes no record is taken without a stall while the
// sequencer idles. a completing byte starts the record program at PC_START;
// its first character goes from that step into the rsp_ output register. the
// program runs one step per character plus one silent step that picks the
// checksum width; the end-of-file record has its own silent step for the format.
// the input is stalled while the program runs and takes the next byte the
// cycle after the final LF is loaded.
// reset clears format, load address, fill count and checksum. when rsp_stall
// is high while an output word is valid, that word holds and the sequencer
// waits on the next character.
// ----------------------------------------------------------------------------
module hex_record_encoder
   import hre_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // byte input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_word_type         req_word,
   // text output
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_word,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   // sequencer
   logic [PC_W-1:0]   pc_ff, pc_in;
   ctrl_word_type     ctrl;

   // configuration
   logic              fmt_ff, fmt_in;
   logic [15:0]       load_addr_ff, load_addr_in;

   // record state
   logic [15:0]       rec_addr_ff, rec_addr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       sum_ff, sum_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              last_ff, last_in;
   logic [7:0]        buf_ff [REC_BYTES];

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   // datapath
   logic              req_take;
   logic              csr_take;
   logic [FILL_W-1:0] fill_next;
   logic              rec_due;
   logic              out_free;
   logic              step_go;
   logic              jump_take;
   logic              more_data;
   logic [7:0]        cnt8;
   logic [7:0]        data_cur;
   logic [15:0]       total;
   logic [7:0]        ck_lo;
   logic [3:0]        nib;
   logic [6:0]        chr;
   logic              run_last;

   assign ctrl      = ucode_rom(pc_ff);
   assign req_stall = (pc_ff != PC_IDLE);
   assign csr_ready = (pc_ff == PC_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;

   assign fill_next = fill_ff + FILL_W'(1);
   assign rec_due   = (fill_next == FILL_W'(REC_BYTES)) || req_word.end_of_data;

   // the sequencer steps when its character can be loaded
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_go   = (pc_ff != PC_IDLE) && (!ctrl.emit || out_free);

   // record fields and checksum
   assign cnt8      = 8'(fill_ff);
   assign data_cur  = buf_ff[idx_ff];
   assign more_data = ({1'b0, idx_ff} + FILL_W'(1)) != fill_ff;
   assign total     = {8'd0, cnt8} + {8'd0, rec_addr_ff[7:0]} + {8'd0, rec_addr_ff[15:8]}
                      + sum_ff;
   assign ck_lo     = (fmt_ff == FMT_MOSTEK) ? total[7:0] : (~total[7:0] + 8'd1);

   always_comb begin
      case (ctrl.jc)
         JC_NONE:     jump_take = 1'b0;
         JC_ALWAYS:   jump_take = 1'b1;
         JC_MOSTEK:   jump_take = (fmt_ff == FMT_MOSTEK);
         JC_INTEL:    jump_take = (fmt_ff == FMT_INTEL);
         JC_MORE:     jump_take = more_data;
         JC_NOT_LAST: jump_take = !last_ff;
         default:     jump_take = 1'b1;
      endcase
   end

   // nibble select for hex digits
   always_comb begin
      case (ctrl.nib)
         NS_CNT_HI: nib = cnt8[7:4];
         NS_CNT_LO: nib = cnt8[3:0];
         NS_A3:     nib = rec_addr_ff[15:12];
         NS_A2:     nib = rec_addr_ff[11:8];
         NS_A1:     nib = rec_addr_ff[7:4];
         NS_A0:     nib = rec_addr_ff[3:0];
         NS_D_HI:   nib = data_cur[7:4];
         NS_D_LO:   nib = data_cur[3:0];
         NS_K3:     nib = total[15:12];
         NS_K2:     nib = total[11:8];
         NS_K1:     nib = ck_lo[7:4];
         NS_K0:     nib = ck_lo[3:0];
         default:   nib = 4'd0;
      endcase
   end

   // character select
   always_comb begin
      case (ctrl.ck)
         CK_START: chr = (fmt_ff == FMT_MOSTEK) ? CHR_SEMI : CHR_COLON;
         CK_HEX:   chr = hex_char(nib);
         CK_LIT:   chr = ctrl.lit;
         default:  chr = ctrl.lit;
      endcase
   end

   // record LF ends the run unless an end-of-file record follows
   assign run_last = ((ctrl.lk == LK_REC) && !last_ff) || (ctrl.lk == LK_EOF);

   // next state
   always_comb begin
      pc_in        = pc_ff;
      fmt_in       = fmt_ff;
      load_addr_in = load_addr_ff;
      rec_addr_in  = rec_addr_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      // output word leaves
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_take) begin
         case (csr_index)
            CSR_RECORD_FORMAT: fmt_in = csr_data[0];
            CSR_LOAD_ADDRESS: begin
               load_addr_in = csr_data;
               rec_addr_in  = csr_data;
            end
            default: ;
         endcase
      end

      // byte accept: store, count, sum
      if (req_take) begin
         fill_in = fill_next;
         sum_in  = sum_ff + {8'd0, req_word.data_byte};
         last_in = req_word.end_of_data;
         if (rec_due) begin
            pc_in = PC_START;
         end
      end

      if (step_go) begin
         pc_in = jump_take ? ctrl.target : (pc_ff + PC_W'(1));
         if (ctrl.emit) begin
            rsp_valid_in          = 1'b1;
            rsp_word_in.text_char = chr;
            rsp_word_in.run_last  = run_last;
         end
         case (ctrl.act)
            ACT_NONE: ;
            ACT_NEXT_BYTE: idx_in = idx_ff + IDX_W'(1);
            ACT_FINISH: begin
               rec_addr_in = rec_addr_ff + {8'd0, cnt8};
               fill_in     = '0;
               sum_in      = '0;
               idx_in      = '0;
            end
            ACT_RELOAD: rec_addr_in = load_addr_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         fmt_ff       <= FMT_INTEL;
         load_addr_ff <= '0;
         rec_addr_ff  <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         idx_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         fmt_ff       <= fmt_in;
         load_addr_ff <= load_addr_in;
         rec_addr_ff  <= rec_addr_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (req_take) begin
         buf_ff[fill_ff[IDX_W-1:0]] <= req_word.data_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef NO_ASSERTIONS
   // buffer never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(REC_BYTES))
      else $error("fill count beyond record size");

   // a record program never starts with an empty buffer
   a_start_nonempty: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_START) |-> (fill_ff != '0))
      else $error("record started with no data");

   // data loop reads only written entries
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_DATA_HI) |-> ({1'b0, idx_ff} < fill_ff))
      else $error("data index past fill count");

   // byte index is back at zero whenever the sequencer idles
   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_IDLE) |-> (idx_ff == '0))
      else $error("byte index not cleared at idle");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hex record encoder: a bit-true encoder model
// predicts every text word, a monitor compares each accepted rsp_ word with
// the oldest prediction, and named tests cover directed corners, random
// images under three idling mixes and a long output hold-off
// ----------------------------------------------------------------------------
module tb;
   import hre_pkg::*;

   // register indexes past the end of the list, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 4;    // sequencer winds down after the last LF
   localparam int TAIL_CYCLES   = 20;   // watch for stray words at the end
   localparam int HOLD_CYCLES   = 300;  // long receiver hold-off

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_word_type         req_word;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_word_type         rsp_word;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_data;

   // idling mix, percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // receiver hold-off, counted down in its own process
   int   hold_left = 0;
   logic hold_active;

   // run statistics
   int error_count   = 0;
   int chars_checked = 0;
   int items_sent    = 0;
   int images_sent   = 0;
   int csr_writes    = 0;

   // encoder model state
   logic         fmt_model;
   logic [15:0]  load_model;
   logic [15:0]  addr_model;
   logic [15:0]  sum_model;
   logic [7:0]   rec_bytes [REC_BYTES];
   int           fill_model;
   rsp_word_type expected_text [$];

   hex_record_encoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // encoder model
   // ------------------------------------------------------------------------

   function automatic void push_char(input logic [6:0] c);
      rsp_word_type w;
      w.text_char = c;
      w.run_last  = 1'b0;
      expected_text.push_back(w);
   endfunction

   // uppercase hex, most significant digit first
   function automatic void push_hex(input logic [15:0] value, input int digits);
      logic [3:0] nib;
      for (int d = digits - 1; d >= 0; d--) begin
         nib = value[d*4 +: 4];
         if (nib < 4'd10) begin
            push_char(CHR_0 + {3'd0, nib});
         end else begin
            push_char(CHR_A + {3'd0, nib} - 7'd10);
         end
      end
   endfunction

   function automatic void push_text(input string s);
      logic [7:0] ch;
      for (int i = 0; i < s.len(); i++) begin
         ch = s[i];
         push_char(ch[6:0]);
      end
   endfunction

   // one data record from the held bytes, then advance the address
   function automatic void emit_record_text();
      logic [7:0]  cnt;
      logic [15:0] total;
      logic [7:0]  chk;
      cnt   = fill_model[7:0];
      total = {8'd0, cnt} + {8'd0, addr_model[7:0]} + {8'd0, addr_model[15:8]} + sum_model;
      chk   = 8'h00 - total[7:0];
      push_char((fmt_model == FMT_MOSTEK) ? CHR_SEMI : CHR_COLON);
      push_hex({8'd0, cnt}, 2);
      push_hex(addr_model, 4);
      if (fmt_model == FMT_INTEL) begin
         push_text("00");
      end
      for (int i = 0; i < fill_model; i++) begin
         push_hex({8'd0, rec_bytes[i[IDX_W-1:0]]}, 2);
      end
      if (fmt_model == FMT_MOSTEK) begin
         push_hex(total, 4);
      end else begin
         push_hex({8'd0, chk}, 2);
      end
      push_char(CHR_LF);
      addr_model = addr_model + {8'd0, cnt};
      fill_model = 0;
      sum_model  = 16'd0;
   endfunction

   // predicts the text caused by one accepted byte
   function automatic void encode_byte(input logic [7:0] b, input logic eod);
      int           depth_prev;
      rsp_word_type w;
      depth_prev = expected_text.size();
      if (fill_model < REC_BYTES) begin
         rec_bytes[fill_model[IDX_W-1:0]] = b;
         fill_model++;
         sum_model = sum_model + {8'd0, b};
      end
      // a full record on the final byte gets no empty record after it
      if (fill_model >= REC_BYTES || (eod && fill_model > 0)) begin
         emit_record_text();
      end
      if (eod) begin
         if (fmt_model == FMT_MOSTEK) begin
            push_text(";00\n");
         end else begin
            push_text(":00000001FF\n");
         end
         // next image starts again from the load address
         addr_model = load_model;
      end
      if (expected_text.size() > depth_prev) begin
         w = expected_text.pop_back();
         w.run_last = 1'b1;
         expected_text.push_back(w);
      end
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      case (idx)
         CSR_RECORD_FORMAT: begin
            fmt_model = data[0];
         end
         CSR_LOAD_ADDRESS: begin
            // presets the running address too, even mid-record
            load_model = data;
            addr_model = data;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void reset_model();
      fmt_model  = FMT_INTEL;
      load_model = 16'd0;
      addr_model = 16'd0;
      sum_model  = 16'd0;
      fill_model = 0;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // one byte word on req_, held until the block takes it
   task automatic send_byte(input logic [7:0] b, input logic eod);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= {b, eod};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_byte(b, eod);
      items_sent++;
      @(negedge clock);
   endtask

   // sender stops until every predicted word has come out
   task automatic drain_text();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_text.size() != 0) @(negedge clock);
   endtask

   // register write, only once the block has gone quiet
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      drain_text();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // biased toward the all-zero and all-one bytes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // extremes and the top of the space, where records wrap
   function automatic logic [15:0] pick_load_address();
      case ($urandom_range(5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'(16'hFFFF - $urandom_range(40));
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // random images, each closed by an end flag; some get a register write
   // between images or in the middle of one
   task automatic run_images(input int target);
      int first_item;
      int len;
      int cut;
      first_item = items_sent;
      while (items_sent - first_item < target) begin
         case ($urandom_range(9))
            0, 1:    write_csr(CSR_RECORD_FORMAT, 16'($urandom_range(16'hFFFF)));
            2:       write_csr(CSR_LOAD_ADDRESS, pick_load_address());
            3:       write_csr($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3,
                               16'($urandom_range(16'hFFFF)));
            default: begin
            end
         endcase
         case ($urandom_range(9))
            0, 1:    len = 16 * $urandom_range(1, 3);
            2:       len = 1;
            default: len = $urandom_range(2, 40);
         endcase
         cut = (len > 1 && $urandom_range(9) == 0) ? $urandom_range(1, len - 1) : 0;
         for (int i = 0; i < len; i++) begin
            if (cut != 0 && i == cut) begin
               if ($urandom_range(1)) begin
                  write_csr(CSR_LOAD_ADDRESS, pick_load_address());
               end else begin
                  write_csr(CSR_RECORD_FORMAT, 16'($urandom_range(16'hFFFF)));
               end
            end
            send_byte(pick_byte(), i == len - 1);
         end
         images_sent++;
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // intel format at reset values, byte extremes as one-byte images
   task automatic test_single_byte_images();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      images_sent += 2;
   endtask

   // mostek near the top: the second record lands past the wrap
   task automatic test_mostek_address_wrap();
      write_csr(CSR_RECORD_FORMAT, {15'd0, FMT_MOSTEK});
      write_csr(CSR_LOAD_ADDRESS, 16'hFFF8);
      for (int i = 0; i < 17; i++) begin
         send_byte(pick_byte(), i == 16);
      end
      images_sent++;
   endtask

   // partial record held while registers change, spare indexes ignored
   task automatic test_csr_while_filling();
      write_csr(CSR_RECORD_FORMAT, {15'd0, FMT_INTEL});
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b0);
      write_csr(CSR_SPARE_2, 16'hFFFF);
      write_csr(CSR_SPARE_3, 16'hFFFF);
      // format in force at send time wins, upper data bits don't matter
      write_csr(CSR_RECORD_FORMAT, 16'hFFFF);
      write_csr(CSR_LOAD_ADDRESS, 16'hFFFF);
      send_byte(8'h55, 1'b1);
      images_sent++;
   endtask

   task automatic test_random_receiver_stalls();
      send_idle_pct = 21;
      rsp_stall_pct = 70;
      run_images(120);
   endtask

   task automatic test_random_sender_gaps();
      send_idle_pct = 70;
      rsp_stall_pct = 21;
      run_images(120);
   endtask

   task automatic test_random_full_rate();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_images(120);
   endtask

   // receiver freezes while the sender keeps offering, so the record
   // program backs up and req_stall holds the input
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_csr(CSR_RECORD_FORMAT, {15'd0, FMT_INTEL});
      hold_left = HOLD_CYCLES;
      for (int i = 0; i < 40; i++) begin
         send_byte(pick_byte(), i == 39);
      end
      drain_text();
      for (int i = 0; i < 5; i++) begin
         send_byte(pick_byte(), i == 4);
      end
      images_sent += 2;
   endtask

   // ------------------------------------------------------------------------
   // receiver side
   // ------------------------------------------------------------------------

   initial begin
      hold_active = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_active = 1'b1;
            hold_left--;
         end else begin
            hold_active = 1'b0;
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= hold_active || ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic report_error(input string msg);
      $display("%0t ERROR %s", $time, msg);
      error_count++;
   endtask

   // every accepted text word against the oldest prediction
   always @(posedge clock) begin : check_text
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_text.size() == 0) begin
            report_error($sformatf("unexpected word text_char %h run_last %b",
                                   rsp_word.text_char, rsp_word.run_last));
         end else begin
            want = expected_text.pop_front();
            if (rsp_word.text_char !== want.text_char) begin
               report_error($sformatf("word %0d text_char %h, expected %h",
                                      chars_checked, rsp_word.text_char, want.text_char));
            end
            if (rsp_word.run_last !== want.run_last) begin
               report_error($sformatf("word %0d run_last %b, expected %b",
                                      chars_checked, rsp_word.run_last, want.run_last));
            end
         end
         chars_checked++;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_RECORD_FORMAT;
      csr_data  = 16'd0;
      send_idle_pct = 21;
      rsp_stall_pct = 70;
      reset_model();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_byte_images();
      test_mostek_address_wrap();
      test_csr_while_filling();
      test_random_receiver_stalls();
      test_random_sender_gaps();
      test_random_full_rate();
      test_backpressure();

      drain_text();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("run: %0d bytes in %0d images, %0d text words checked, %0d register writes",
               items_sent, images_sent, chars_checked, csr_writes);
      $display("run: intel and mostek records, address wrap, mid-record register writes, "
               , "output hold-off");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: filelist.f
src/hre_pkg.sv
src/hex_record_encoder.sv
verif/tb.sv
